// ===== hdl/ryc_pkg.sv =====
// shared types and constants of the rgb to yuv 4:2:0 converter
package ryc_pkg;

  localparam int unsigned DEF_MAX_WIDTH   = 2048;
  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  localparam int unsigned REG_W      = 12;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned MAX_HEIGHT = 2048;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 12'd1280;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 12'd720;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       odd_col;
    logic       odd_row;
    logic       frame_end;
  } pix_t;

endpackage

// ===== hdl/ryc_ram.sv =====
// generic simple dual port ram with registered read
module ryc_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ryc_front.sv =====
// front end: configuration registers, raster position tracking and pixel tagging
module ryc_front #(
  parameter int unsigned MAX_WIDTH = 2048,
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2,
  localparam int unsigned IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ryc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ryc_pkg::REG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  input  logic [7:0]                       red_i,
  input  logic [7:0]                       green_i,
  input  logic [7:0]                       blue_i,
  input  logic                             frame_start_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output ryc_pkg::pix_t                    q_pix_o,
  output logic [IW-1:0]                    q_idx_o
);
  import ryc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW = (WW > REG_W) ? WW : REG_W;

  logic [REG_W-1:0] frame_width_q, frame_height_q;
  logic [CW-1:0]    col_q, col_d, col_eff;
  logic [ROW_W-1:0] row_q, row_d, row_eff;
  logic [XW-1:0]    fw_ext, w_eff, w_last;
  logic [REG_W-1:0] h_eff, h_last;
  logic             last_col, last_row, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = XW'(frame_width_q);
    if (fw_ext < XW'(2)) begin
      w_eff = XW'(2);
    end else if (fw_ext > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    w_last = w_eff - XW'(1);

    if (frame_height_q < REG_W'(2)) begin
      h_eff = REG_W'(2);
    end else if (frame_height_q > REG_W'(MAX_HEIGHT)) begin
      h_eff = REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_q;
    end
    h_last = h_eff - REG_W'(1);

    col_eff  = frame_start_i ? '0 : col_q;
    row_eff  = frame_start_i ? '0 : row_q;
    last_col = XW'(col_eff) >= w_last;
    last_row = REG_W'(row_eff) >= h_last;

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_eff + ROW_W'(1);
    end else begin
      col_d = col_eff + CW'(1);
      row_d = row_eff;
    end
  end

  assign accept = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign q_push_o            = accept;
  assign q_pix_o.red         = red_i;
  assign q_pix_o.green       = green_i;
  assign q_pix_o.blue        = blue_i;
  assign q_pix_o.odd_col     = col_eff[0];
  assign q_pix_o.odd_row     = row_eff[0];
  assign q_pix_o.frame_end   = last_col && last_row;
  assign q_idx_o             = IW'(col_eff >> 1);

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(col_q) < XW'(MAX_WIDTH))
    else $error("column position beyond maximum width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    REG_W'(row_q) < REG_W'(MAX_HEIGHT))
    else $error("row position beyond maximum height");

endmodule

// ===== hdl/ryc_queue.sv =====
// short queue between the front end and the conversion pipeline
module ryc_queue #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned IW    = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ryc_pkg::pix_t pix_i,
  input  logic [IW-1:0] idx_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ryc_pkg::pix_t pix_o,
  output logic [IW-1:0] idx_o
);
  import ryc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  pix_t          pix_q [DEPTH];
  logic [IW-1:0] idx_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = count_q == NW'(DEPTH);
  assign valid_o = count_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign pix_o   = pix_q[rd_ptr_q];
  assign idx_o   = idx_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      pix_q[wr_ptr_q] <= pix_i;
      idx_q[wr_ptr_q] <= idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("transaction pushed into a full queue");

endmodule

// ===== hdl/ryc_back.sv =====
// conversion pipeline: color matrix, chroma pairing, line store and output register
module ryc_back #(
  parameter int unsigned LINE_DEPTH = 1024,
  localparam int unsigned IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ryc_pkg::pix_t q_pix_i,
  input  logic [IW-1:0] q_idx_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    luma_o,
  output logic          chroma_valid_o,
  output logic [7:0]    cb_avg_o,
  output logic [7:0]    cr_avg_o,
  output logic          frame_end_o
);
  import ryc_pkg::*;

  localparam int unsigned PW = 24;
  localparam int unsigned SW = 26;
  localparam logic [PW-1:0] CY_R = 24'd19595;
  localparam logic [PW-1:0] CY_G = 24'd38470;
  localparam logic [PW-1:0] CY_B = 24'd7471;
  localparam logic [PW-1:0] CU_R = 24'd11036;
  localparam logic [PW-1:0] CU_G = 24'd21732;
  localparam logic [PW-1:0] CV_G = 24'd27440;
  localparam logic [PW-1:0] CV_B = 24'd5328;
  localparam logic [PW-1:0] OFFSET_Q16 = 24'h800000;

  typedef struct packed {
    logic [PW-1:0] yr, yg, yb, cur, cug, cvg, cvb;
    logic [6:0]    r_half, b_half;
    logic          odd_col, odd_row, frame_end;
    logic [IW-1:0] idx;
  } prod_t;

  typedef struct packed {
    logic [7:0]    y, cb, cr;
    logic          odd_col, odd_row, frame_end;
    logic [IW-1:0] idx;
  } byte_t;

  typedef struct packed {
    logic [7:0] y;
    logic [8:0] sum_cb, sum_cr;
    logic       chroma, frame_end;
  } mem_t;

  function automatic logic [7:0] to_byte(input logic signed [SW-1:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v[SW-1:16] > (SW-16)'(255)) begin
      res = 8'd255;
    end else begin
      res = v[23:16];
    end
    return res;
  endfunction

  logic  adv;
  logic  p_v_q, b_v_q, m_v_q, o_v_q;
  prod_t p_q, p_d;
  byte_t b_q, b_d;
  mem_t  m_q, m_d;
  logic [15:0] held_q;
  logic        ram_we, ram_re;
  logic [17:0] ram_rdata;
  logic [9:0]  cb_tot, cr_tot;
  logic signed [SW-1:0] y_s, cb_s, cr_s;
  logic [7:0]  luma_q, cb_q, cr_q;
  logic        chroma_q, fend_q;

  assign adv     = !o_v_q || !out_stall_i;
  assign q_pop_o = adv && q_valid_i;

  // products
  always_comb begin
    p_d.yr        = PW'(q_pix_i.red) * CY_R;
    p_d.yg        = PW'(q_pix_i.green) * CY_G;
    p_d.yb        = PW'(q_pix_i.blue) * CY_B;
    p_d.cur       = PW'(q_pix_i.red) * CU_R;
    p_d.cug       = PW'(q_pix_i.green) * CU_G;
    p_d.cvg       = PW'(q_pix_i.green) * CV_G;
    p_d.cvb       = PW'(q_pix_i.blue) * CV_B;
    p_d.r_half    = q_pix_i.red[7:1];
    p_d.b_half    = q_pix_i.blue[7:1];
    p_d.odd_col   = q_pix_i.odd_col;
    p_d.odd_row   = q_pix_i.odd_row;
    p_d.frame_end = q_pix_i.frame_end;
    p_d.idx       = q_idx_i;
  end

  // sums and clamping
  always_comb begin
    y_s  = $signed({2'b00, p_q.yr + p_q.yg + p_q.yb});
    cb_s = $signed({2'b00, PW'({p_q.b_half, 16'd0}) + OFFSET_Q16})
         - $signed({2'b00, p_q.cur + p_q.cug});
    cr_s = $signed({2'b00, PW'({p_q.r_half, 16'd0}) + OFFSET_Q16})
         - $signed({2'b00, p_q.cvg + p_q.cvb});
    b_d.y         = to_byte(y_s);
    b_d.cb        = to_byte(cb_s);
    b_d.cr        = to_byte(cr_s);
    b_d.odd_col   = p_q.odd_col;
    b_d.odd_row   = p_q.odd_row;
    b_d.frame_end = p_q.frame_end;
    b_d.idx       = p_q.idx;
  end

  // column pairing and line store access
  always_comb begin
    m_d.y         = b_q.y;
    m_d.sum_cb    = {1'b0, held_q[7:0]} + {1'b0, b_q.cb};
    m_d.sum_cr    = {1'b0, held_q[15:8]} + {1'b0, b_q.cr};
    m_d.chroma    = b_q.odd_col && b_q.odd_row;
    m_d.frame_end = b_q.frame_end;
  end

  assign ram_we = adv && b_v_q && b_q.odd_col && !b_q.odd_row;
  assign ram_re = adv && b_v_q && b_q.odd_col && b_q.odd_row;

  ryc_ram #(
    .WIDTH (18),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (b_q.idx),
    .wdata_i ({m_d.sum_cr, m_d.sum_cb}),
    .re_i    (ram_re),
    .raddr_i (b_q.idx),
    .rdata_o (ram_rdata)
  );

  assign cb_tot = 10'(m_q.sum_cb) + 10'(ram_rdata[8:0]);
  assign cr_tot = 10'(m_q.sum_cr) + 10'(ram_rdata[17:9]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q      <= p_d;
      b_q      <= b_d;
      m_q      <= m_d;
      luma_q   <= m_q.y;
      cb_q     <= m_q.chroma ? cb_tot[9:2] : 8'd0;
      cr_q     <= m_q.chroma ? cr_tot[9:2] : 8'd0;
      chroma_q <= m_q.chroma;
      fend_q   <= m_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      m_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
      held_q <= '0;
    end else if (adv) begin
      p_v_q <= q_valid_i;
      b_v_q <= p_v_q;
      m_v_q <= b_v_q;
      o_v_q <= m_v_q;
      if (b_v_q && !b_q.odd_col) begin
        held_q <= {b_q.cr, b_q.cb};
      end
    end
  end

  assign out_valid_o    = o_v_q;
  assign luma_o         = luma_q;
  assign chroma_valid_o = chroma_q;
  assign cb_avg_o       = cb_q;
  assign cr_avg_o       = cr_q;
  assign frame_end_o    = fend_q;

  a_ram_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line store written and read by one transaction");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && out_stall_i) |=> (o_v_q && $stable(m_v_q) && $stable(held_q)))
    else $error("pipeline moved while output stalled");

endmodule

// ===== hdl/rgb_to_yuv420_converter.sv =====
// top level of the rgb to yuv 4:2:0 converter
// Takes one RGB pixel per clock in raster order while in_stall_o is low and returns
// one transaction per pixel with its luma, plus averaged Cb/Cr on the odd column of each
// odd row. Sustained rate is one pixel per cycle while out_stall_i stays low; the line
// store sees at most one access per pixel (on odd columns only: a write on even rows, a
// read on odd rows), so it does not limit that rate. An accepted input passes through
// the queue (two entries by default) and then four registers of the conversion
// pipeline (products, clamping, pairing with the line store access, output register).
// The line store holds MAX_WIDTH/2 entries of two 9-bit pair sums and needs no
// clearing pass after reset. The user must write frame_width and frame_height through
// the configuration port only while the block is idle; the block itself does not
// enforce this. Both are clamped to 2..MAX_WIDTH and 2..2048.
module rgb_to_yuv420_converter #(
  parameter int unsigned MAX_WIDTH   = ryc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned QUEUE_DEPTH = ryc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ryc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ryc_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    luma_o,
  output logic                          chroma_valid_o,
  output logic [7:0]                    cb_avg_o,
  output logic [7:0]                    cr_avg_o,
  output logic                          frame_end_o
);
  import ryc_pkg::*;

  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic          q_push, q_full, q_pop, q_valid;
  pix_t          push_pix, pop_pix;
  logic [IW-1:0] push_idx, pop_idx;

  ryc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_pix_o       (push_pix),
    .q_idx_o       (push_idx)
  );

  ryc_queue #(
    .DEPTH (QUEUE_DEPTH),
    .IW    (IW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pix_i   (push_pix),
    .idx_i   (push_idx),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .pix_o   (pop_pix),
    .idx_o   (pop_idx)
  );

  ryc_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pix_i        (pop_pix),
    .q_idx_i        (pop_idx),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .luma_o         (luma_o),
    .chroma_valid_o (chroma_valid_o),
    .cb_avg_o       (cb_avg_o),
    .cr_avg_o       (cr_avg_o),
    .frame_end_o    (frame_end_o)
  );

  assign in_stall_o = q_full;

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench of the rgb to yuv 4:2:0 converter
module tb_top;
  import ryc_pkg::*;

  localparam int unsigned LINE_DEPTH   = DEF_MAX_WIDTH / 2;
  localparam int          CY_R         = 19595;
  localparam int          CY_G         = 38470;
  localparam int          CY_B         = 7471;
  localparam int          CU_R         = 11036;
  localparam int          CU_G         = 21732;
  localparam int          CV_G         = 27440;
  localparam int          CV_B         = 5328;
  localparam int          OFFSET_Q16   = 128 * 65536;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned WIDE_PIXELS  = 200;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam int unsigned DIRECTED_ROWS = 25;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PATTERN
  } stall_mode_e;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb_avg;
    logic [7:0] cr_avg;
    logic       frame_end;
  } yuv_result_t;

  typedef struct packed {
    logic             set_cfg;
    logic [REG_W-1:0] cfg_width;
    logic [REG_W-1:0] cfg_height;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             frame_start;
    logic             typed;
    yuv_result_t      want;
  } pixel_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic                 frame_start;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           luma;
  logic                 chroma_valid;
  logic [7:0]           cb_avg;
  logic [7:0]           cr_avg;
  logic                 frame_end;

  // converter model state
  logic [REG_W-1:0] model_width;
  logic [REG_W-1:0] model_height;
  int unsigned      next_col;
  int unsigned      next_row;
  logic [7:0]       held_cb;
  logic [7:0]       held_cr;
  logic [8:0]       cb_pair_line [LINE_DEPTH];
  logic [8:0]       cr_pair_line [LINE_DEPTH];

  yuv_result_t expected_results [$];
  pixel_row_t  directed_rows [DIRECTED_ROWS];

  int unsigned errors;
  int unsigned results_checked;
  int unsigned chroma_blocks;
  int unsigned frames_done;
  int unsigned pixels_sent;
  int unsigned size_settings;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          steady_sender;

  rgb_to_yuv420_converter u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .frame_start_i  (frame_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .luma_o         (luma),
    .chroma_valid_o (chroma_valid),
    .cb_avg_o       (cb_avg),
    .cr_avg_o       (cr_avg),
    .frame_end_o    (frame_end)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] q16_to_byte(input int acc);
    if (acc < 0) return 8'd0;
    if ((acc >>> 16) > 255) return 8'd255;
    return acc[23:16];
  endfunction

  function automatic int unsigned clamp_size(input logic [REG_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic yuv_result_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input logic fs);
    int          ri;
    int          gi;
    int          bi;
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    logic [7:0]  cb;
    logic [7:0]  cr;
    logic [8:0]  sum_cb;
    logic [8:0]  sum_cr;
    logic [9:0]  tot_cb;
    logic [9:0]  tot_cr;
    logic        last_col;
    logic        last_row;
    yuv_result_t res;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    w = clamp_size(model_width, DEF_MAX_WIDTH);
    h = clamp_size(model_height, MAX_HEIGHT);
    if (fs) begin
      next_col = 0;
      next_row = 0;
    end
    res = '0;
    res.luma = q16_to_byte(CY_R * ri + CY_G * gi + CY_B * bi);
    cb = q16_to_byte(((bi >> 1) << 16) + OFFSET_Q16 - CU_R * ri - CU_G * gi);
    cr = q16_to_byte(((ri >> 1) << 16) + OFFSET_Q16 - CV_G * gi - CV_B * bi);
    idx = (next_col >> 1) % LINE_DEPTH;
    if (next_col % 2 == 0) begin
      held_cb = cb;
      held_cr = cr;
    end else begin
      sum_cb = held_cb + cb;
      sum_cr = held_cr + cr;
      if (next_row % 2 == 0) begin
        cb_pair_line[idx] = sum_cb;
        cr_pair_line[idx] = sum_cr;
      end else begin
        tot_cb = sum_cb + cb_pair_line[idx];
        tot_cr = sum_cr + cr_pair_line[idx];
        res.cb_avg = tot_cb[9:2];
        res.cr_avg = tot_cr[9:2];
        res.chroma_valid = 1'b1;
      end
    end
    last_col = next_col >= w - 1;
    last_row = next_row >= h - 1;
    res.frame_end = last_col && last_row;
    if (last_col) begin
      next_col = 0;
      next_row = last_row ? 0 : next_row + 1;
    end else begin
      next_col++;
    end
    return res;
  endfunction

  function automatic logic [7:0] pick_component();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               field, results_checked, got, want);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic fs, input logic typed, input yuv_result_t want);
    yuv_result_t predicted;
    if (burst_left == 0) begin
      if (!steady_sender) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          in_valid    = 1'b0;
          red         = 8'($urandom);
          green       = 8'($urandom);
          blue        = 8'($urandom);
          frame_start = 1'($urandom);
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid    = 1'b1;
    red         = r;
    green       = g;
    blue        = b;
    frame_start = fs;
    do @(posedge clk); while (in_stall);
    predicted = convert_pixel(r, g, b, fs);
    expected_results.push_back(typed ? want : predicted);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_frame_size(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
    wait_drained();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data  = w;
    @(negedge clk);
    cfg_index = CFG_FRAME_HEIGHT;
    cfg_data  = h;
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = REG_W'($urandom);
    model_width  = w;
    model_height = h;
    size_settings++;
  endtask

  always @(posedge clk) begin
    yuv_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction, luma", luma, 0);
      end else begin
        want = expected_results.pop_front();
        if (luma !== want.luma) report_mismatch("luma", luma, want.luma);
        if (chroma_valid !== want.chroma_valid)
          report_mismatch("chroma_valid", chroma_valid, want.chroma_valid);
        if (cb_avg !== want.cb_avg) report_mismatch("cb_avg", cb_avg, want.cb_avg);
        if (cr_avg !== want.cr_avg) report_mismatch("cr_avg", cr_avg, want.cr_avg);
        if (frame_end !== want.frame_end)
          report_mismatch("frame_end", frame_end, want.frame_end);
        results_checked++;
        if (want.chroma_valid) chroma_blocks++;
        if (want.frame_end) frames_done++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_results.size());
      $display("[rgb_to_yuv420_converter] ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    stall_mode_e mode;
    int unsigned span;
    int unsigned period;
    int unsigned duty;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      mode   = stall_mode_e'($urandom_range(0, 3));
      span   = $urandom_range(16, 160);
      period = $urandom_range(2, 12);
      duty   = $urandom_range(1, period - 1);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  out_stall = 1'b0;
          STALL_LIGHT: out_stall = ($urandom_range(0, 4) == 0);
          STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
          default:     out_stall = (k % period) < duty;
        endcase
      end
    end
  end

  initial begin
    logic [REG_W-1:0] new_w;
    logic [REG_W-1:0] new_h;
    int unsigned      kind;
    int unsigned      cur_w;
    int unsigned      pixels;
    int unsigned      random_items;
    logic             keep_position;
    logic             fs;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_FRAME_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    red         = '0;
    green       = '0;
    blue        = '0;
    frame_start = 1'b0;

    model_width  = FRAME_WIDTH_RST;
    model_height = FRAME_HEIGHT_RST;
    next_col     = 0;
    next_row     = 0;
    held_cb      = '0;
    held_cr      = '0;

    // set_cfg, width, height, r, g, b, frame_start, typed, expected
    directed_rows = '{
      '{0, 0, 0, 0, 0, 0, 1, 1, '{0, 0, 0, 0, 0}},
      '{0, 0, 0, 255, 255, 255, 0, 1, '{255, 0, 0, 0, 0}},
      // out-of-range sizes clamp to a 2x2 frame
      '{1, 0, 1, 255, 255, 255, 1, 1, '{255, 0, 0, 0, 0}},
      '{0, 0, 0, 255, 255, 255, 0, 1, '{255, 0, 0, 0, 0}},
      '{0, 0, 0, 255, 255, 255, 0, 1, '{255, 0, 0, 0, 0}},
      '{0, 0, 0, 255, 255, 255, 0, 1, '{255, 1, 127, 127, 1}},
      '{0, 0, 0, 255, 0, 0, 0, 1, '{76, 0, 0, 0, 0}},
      '{0, 0, 0, 255, 0, 0, 0, 1, '{76, 0, 0, 0, 0}},
      '{0, 0, 0, 255, 0, 0, 0, 1, '{76, 0, 0, 0, 0}},
      '{0, 0, 0, 255, 0, 0, 0, 1, '{76, 1, 85, 255, 1}},
      '{0, 0, 0, 0, 0, 255, 0, 1, '{29, 0, 0, 0, 0}},
      '{0, 0, 0, 0, 0, 255, 0, 1, '{29, 0, 0, 0, 0}},
      '{0, 0, 0, 0, 0, 255, 0, 1, '{29, 0, 0, 0, 0}},
      '{0, 0, 0, 0, 0, 255, 0, 1, '{29, 1, 255, 107, 1}},
      // odd width, last column gives luma only
      '{1, 3, 2, 10, 200, 30, 1, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 0, 250, 5, 128, 0, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 0, 77, 77, 77, 0, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 0, 1, 2, 3, 0, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 0, 128, 128, 128, 0, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 0, 200, 100, 50, 0, 0, '{0, 0, 0, 0, 0}},
      // size shrinks mid-frame, position beyond the new width ends the row
      '{1, 12'hFFF, 12'hFFF, 255, 0, 255, 1, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 0, 0, 255, 0, 0, 0, '{0, 0, 0, 0, 0}},
      '{1, 2, 2, 12, 34, 56, 0, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 0, 170, 85, 15, 0, 0, '{0, 0, 0, 0, 0}},
      '{0, 0, 0, 254, 1, 127, 0, 0, '{0, 0, 0, 0, 0}}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    steady_sender = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_cfg)
        write_frame_size(directed_rows[i].cfg_width, directed_rows[i].cfg_height);
      send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                 directed_rows[i].frame_start, directed_rows[i].typed, directed_rows[i].want);
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      cur_w = clamp_size(model_width, DEF_MAX_WIDTH);
      kind  = $urandom_range(0, 19);
      if (kind < 12) begin
        new_w = REG_W'(2 * $urandom_range(1, 8));
        new_h = REG_W'(2 * $urandom_range(1, 4));
      end else if (kind < 15) begin
        new_w = REG_W'($urandom_range(2, 15));
        new_h = REG_W'($urandom_range(2, 9));
      end else if (kind < 17) begin
        new_w = REG_W'($urandom_range(0, 1));
        new_h = REG_W'($urandom_range(0, 1));
      end else if (kind < 18) begin
        new_w = REG_W'($urandom_range(2, 8));
        new_h = REG_W'($urandom_range(2049, 4095));
      end else begin
        new_w = REG_W'($urandom_range(2, cur_w > 16 ? 16 : cur_w));
        new_h = REG_W'($urandom_range(1, 4));
      end
      // the line store is only read where the previous even row wrote it
      keep_position = clamp_size(new_w, DEF_MAX_WIDTH) <= cur_w &&
                      (kind >= 18 || $urandom_range(0, 2) == 0);
      write_frame_size(new_w, new_h);
      steady_sender = ($urandom_range(0, 3) == 0);
      pixels = 2 * clamp_size(new_w, DEF_MAX_WIDTH) * clamp_size(new_h, MAX_HEIGHT) + 4;
      pixels = $urandom_range(1, pixels > 160 ? 160 : pixels);
      for (int unsigned n = 0; n < pixels; n++) begin
        fs = (n == 0) ? !keep_position : ($urandom_range(0, 99) == 0);
        if ($urandom_range(0, 249) == 0) wait_drained();
        send_pixel(pick_component(), pick_component(), pick_component(), fs, 1'b0, '0);
        random_items++;
      end
    end

    // widest frame setting, start of its first row
    write_frame_size(12'hFFF, 12'd2);
    steady_sender = 1'b0;
    for (int unsigned n = 0; n < WIDE_PIXELS; n++)
      send_pixel(pick_component(), pick_component(), pick_component(), n == 0, 1'b0, '0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d pixels over %0d frame size settings, checked %0d results",
             pixels_sent, size_settings, results_checked);
    $display("saw %0d chroma blocks and %0d frame ends, %0d mismatches",
             chroma_blocks, frames_done, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[rgb_to_yuv420_converter] OK");
    end else begin
      $display("[rgb_to_yuv420_converter] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ryc_pkg.sv
hdl/ryc_ram.sv
hdl/ryc_front.sv
hdl/ryc_queue.sv
hdl/ryc_back.sv
hdl/rgb_to_yuv420_converter.sv
test/tb_top.sv
